>>> sv/swdik_pkg.sv
// package for the swerve drive inverse kinematics block
// types, constants and small helpers; no dependencies
package swdik_pkg;

  // build-time defaults and fixed constants
  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int ATAN_TAB_LEN         = 24;
  localparam int SQRT_STEPS           = 16;
  localparam int DIV_STEPS            = 16;
  localparam int PI_Q16               = 205887;
  localparam int PI_Q13               = 25736;

  // internal datapath widths
  localparam int CW = 27;  // cordic x and y
  localparam int ZW = 20;  // angle accumulator, Q.16
  localparam int SW = 32;  // root and remainder words

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASE   = 2'd0,
    CFG_TRACK  = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] BASE_RST   = 16'd11796;
  localparam logic [15:0] TRACK_RST  = 16'd11796;
  localparam logic [15:0] RADIUS_RST = 16'd3277;

  // input item
  typedef struct packed {
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_left;
    logic signed [15:0] yaw_rate;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [1:0]         wheel_index;
    logic signed [15:0] pivot_angle;
    logic [15:0]        linear_speed;
    logic [15:0]        wheel_rate;
    logic               last_wheel;
  } res_t;

  // cordic and square root stage contents
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [SW-1:0]        rem;
    logic [SW-1:0]        root;
    logic [1:0]           k;
    logic                 zero;
  } loop_t;

  // divider stage contents
  typedef struct packed {
    logic [SW-1:0]      rem;
    logic [15:0]        quo;
    logic signed [15:0] angle;
    logic [15:0]        speed;
    logic [1:0]         k;
    logic               zero;
    logic               sat;
  } div_t;

  // atan(2^-i) in Q.16
  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 20'sd51472;
      1:  r = 20'sd30386;
      2:  r = 20'sd16055;
      3:  r = 20'sd8150;
      4:  r = 20'sd4091;
      5:  r = 20'sd2047;
      6:  r = 20'sd1024;
      7:  r = 20'sd512;
      8:  r = 20'sd256;
      9:  r = 20'sd128;
      10: r = 20'sd64;
      11: r = 20'sd32;
      12: r = 20'sd16;
      13: r = 20'sd8;
      14: r = 20'sd4;
      15: r = 20'sd2;
      16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round Q.26 to Q.12 half up and saturate to 16 bits
  function automatic logic signed [15:0] round_sat(input logic signed [34:0] v);
    logic signed [34:0] t;
    t = (v + 35'sd8192) >>> 14;
    if (t > 35'sd32767) begin
      t = 35'sd32767;
    end else if (t < -35'sd32768) begin
      t = -35'sd32768;
    end
    return t[15:0];
  endfunction

endpackage

>>> sv/swdik_front.sv
// command holding register, wheel sequencer, contact velocity and prep stages
// depends on swdik_pkg
module swdik_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [15:0]          base_i,
  input  logic [15:0]          track_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swdik_pkg::cmd_t      in_data_i,
  output logic                 out_valid_o,
  output swdik_pkg::loop_t     out_data_o
);

  swdik_pkg::cmd_t cmd_q;
  logic            cmd_v_q;
  logic [1:0]      k_q;
  logic            issue;
  logic            accept;

  // sequencer: one wheel per cycle from the held command, while adv_i is high
  assign issue      = cmd_v_q && adv_i;
  assign in_ready_o = !cmd_v_q || (adv_i && (k_q == 2'd3));
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_v_q <= 1'b0;
      k_q     <= 2'd0;
    end else if (accept) begin
      cmd_v_q <= 1'b1;
      k_q     <= 2'd0;
    end else if (issue && (k_q == 2'd3)) begin
      cmd_v_q <= 1'b0;
    end else if (issue) begin
      k_q <= k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i;
    end
  end

  // stage 1: yaw rate times half-distances
  logic                v1_q;
  logic signed [32:0]  wt1_q, wb1_q;
  logic signed [15:0]  vx1_q, vy1_q;
  logic [1:0]          k1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wt1_q <= cmd_q.yaw_rate * $signed({1'b0, track_i});
      wb1_q <= cmd_q.yaw_rate * $signed({1'b0, base_i});
      vx1_q <= cmd_q.vel_forward;
      vy1_q <= cmd_q.vel_left;
      k1_q  <= k_q;
    end
  end

  // stage 2: contact components, rounded and saturated
  logic               v2_q;
  logic signed [15:0] x2_q, y2_q;
  logic [1:0]         k2_q;
  logic signed [34:0] cx, cy, wt_e, wb_e;

  always_comb begin
    wt_e = 35'(wt1_q);
    wb_e = 35'(wb1_q);
    cx   = 35'(vx1_q) <<< 14;
    cy   = 35'(vy1_q) <<< 14;
    cx   = k1_q[0] ? (cx + wt_e) : (cx - wt_e);
    cy   = k1_q[1] ? (cy - wb_e) : (cy + wb_e);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x2_q <= swdik_pkg::round_sat(cx);
      y2_q <= swdik_pkg::round_sat(cy);
      k2_q <= k1_q;
    end
  end

  // stage 3: squared magnitude and cordic half-plane prep
  logic                       v3_q;
  swdik_pkg::loop_t           l3_q, l3_d;
  logic signed [31:0]         xs, ys;
  logic signed [swdik_pkg::CW-1:0] xe, ye;

  always_comb begin
    xs = x2_q * x2_q;
    ys = y2_q * y2_q;
    xe = swdik_pkg::CW'(x2_q);
    ye = swdik_pkg::CW'(y2_q);
    l3_d.rem  = swdik_pkg::SW'(xs) + swdik_pkg::SW'(ys);
    l3_d.root = '0;
    l3_d.k    = k2_q;
    l3_d.zero = (x2_q == 16'sd0) && (y2_q == 16'sd0);
    if (x2_q < 16'sd0) begin
      l3_d.x = (-xe) <<< 8;
      l3_d.y = (-ye) <<< 8;
      l3_d.z = (y2_q >= 16'sd0) ? swdik_pkg::ZW'(swdik_pkg::PI_Q16)
                                : -swdik_pkg::ZW'(swdik_pkg::PI_Q16);
    end else begin
      l3_d.x = xe <<< 8;
      l3_d.y = ye <<< 8;
      l3_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      l3_q <= l3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = l3_q;

endmodule

>>> sv/swdik_cordic.sv
// pipelined cordic vectoring and restoring square root, one step per stage
// depends on swdik_pkg
module swdik_cordic #(
  parameter int AngleIterations = swdik_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             in_valid_i,
  input  swdik_pkg::loop_t in_data_i,
  output logic             out_valid_o,
  output swdik_pkg::loop_t out_data_o
);

  localparam int Loop = (AngleIterations > swdik_pkg::SQRT_STEPS) ?
                        AngleIterations : swdik_pkg::SQRT_STEPS;

  swdik_pkg::loop_t tap   [Loop+1];
  logic             tap_v [Loop+1];

  assign tap[0]   = in_data_i;
  assign tap_v[0] = in_valid_i;

  for (genvar j = 0; j < Loop; j++) begin : g_st
    swdik_pkg::loop_t cr, sr, st_d, st_q;
    logic             v_q;

    // one cordic rotation
    if ((j < AngleIterations) && (j < swdik_pkg::ATAN_TAB_LEN)) begin : g_rot
      always_comb begin
        cr = tap[j];
        if (tap[j].y > 0) begin
          cr.x = tap[j].x + (tap[j].y >>> j);
          cr.y = tap[j].y - (tap[j].x >>> j);
          cr.z = tap[j].z + swdik_pkg::atan_q16(j);
        end else begin
          cr.x = tap[j].x - (tap[j].y >>> j);
          cr.y = tap[j].y + (tap[j].x >>> j);
          cr.z = tap[j].z - swdik_pkg::atan_q16(j);
        end
      end
    end else begin : g_rot_pass
      assign cr = tap[j];
    end

    // one root digit
    if (j < swdik_pkg::SQRT_STEPS) begin : g_sq
      localparam logic [swdik_pkg::SW-1:0] Bit = swdik_pkg::SW'(1) << (30 - 2 * j);
      logic [swdik_pkg::SW-1:0] trial;
      always_comb begin
        sr    = tap[j];
        trial = tap[j].root + Bit;
        if (tap[j].rem >= trial) begin
          sr.rem  = tap[j].rem - trial;
          sr.root = (tap[j].root >> 1) + Bit;
        end else begin
          sr.root = tap[j].root >> 1;
        end
      end
    end else begin : g_sq_pass
      assign sr = tap[j];
    end

    always_comb begin
      st_d      = cr;
      st_d.rem  = sr.rem;
      st_d.root = sr.root;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (adv_i) begin
        v_q <= tap_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q <= st_d;
      end
    end

    assign tap[j+1]   = st_q;
    assign tap_v[j+1] = v_q;
  end

  assign out_valid_o = tap_v[Loop];
  assign out_data_o  = tap[Loop];

endmodule

>>> sv/swdik_div.sv
// finish stage (root rounding, angle rounding) and pipelined rate divider
// depends on swdik_pkg
module swdik_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [15:0]      radius_i,
  input  logic             in_valid_i,
  input  swdik_pkg::loop_t in_data_i,
  output logic             out_valid_o,
  output swdik_pkg::div_t  out_data_o
);

  localparam logic signed [swdik_pkg::ZW-1:0] PiZ = swdik_pkg::ZW'(swdik_pkg::PI_Q13);

  // finish stage
  swdik_pkg::div_t            f_d;
  logic [swdik_pkg::SW-1:0]   sp;
  logic signed [swdik_pkg::ZW-1:0] za;

  always_comb begin
    sp = (in_data_i.rem > in_data_i.root) ? (in_data_i.root + 32'd1) : in_data_i.root;
    za = (in_data_i.z + swdik_pkg::ZW'(4)) >>> 3;
    if (za > PiZ) begin
      za = PiZ;
    end else if (za < -PiZ) begin
      za = -PiZ;
    end
    f_d.zero  = in_data_i.zero;
    f_d.k     = in_data_i.k;
    f_d.speed = in_data_i.zero ? 16'd0 : sp[15:0];
    f_d.angle = in_data_i.zero ? 16'sd0 : za[15:0];
    f_d.rem   = {4'd0, f_d.speed, 12'd0} + swdik_pkg::SW'(radius_i >> 1);
    f_d.sat   = f_d.rem >= {radius_i, 16'd0};
    f_d.quo   = '0;
  end

  swdik_pkg::div_t tap   [swdik_pkg::DIV_STEPS+1];
  logic            tap_v [swdik_pkg::DIV_STEPS+1];
  swdik_pkg::div_t f_q;
  logic            f_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (adv_i) begin
      f_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f_q <= f_d;
    end
  end

  assign tap[0]   = f_q;
  assign tap_v[0] = f_v_q;

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < swdik_pkg::DIV_STEPS; j++) begin : g_st
    localparam int Pos = swdik_pkg::DIV_STEPS - 1 - j;
    swdik_pkg::div_t          st_d, st_q;
    logic                     v_q;
    logic [swdik_pkg::SW-1:0] dd;

    always_comb begin
      st_d = tap[j];
      dd   = swdik_pkg::SW'(radius_i) << Pos;
      if (tap[j].rem >= dd) begin
        st_d.rem      = tap[j].rem - dd;
        st_d.quo[Pos] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (adv_i) begin
        v_q <= tap_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q <= st_d;
      end
    end

    assign tap[j+1]   = st_q;
    assign tap_v[j+1] = v_q;
  end

  assign out_valid_o = tap_v[swdik_pkg::DIV_STEPS];
  assign out_data_o  = tap[swdik_pkg::DIV_STEPS];

endmodule

>>> sv/swerve_drive_inverse_kinematics_top.sv
// top level of the swerve drive inverse kinematics block
// depends on swdik_pkg, swdik_front, swdik_cordic, swdik_div
//
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one chassis command;
//   out channel (out_valid_o/out_ready_i/out_data_o) gives four wheel items
//   per command, front-left, front-right, rear-left, rear-right, the last
//   one flagged with last_wheel.
//   cfg channel writes base length (0), track width (1), rolling radius (2);
//   it is always ready and must only be used while the block is idle.
// Throughput: one wheel item per cycle while the output is not stalled, set by
//   the single shared output channel; the wheel sequencer feeds the pipeline.
// Each wheel item passes the command register, the front stages, the
//   cordic/root stages, the finish stage, the divider stages and the output
//   register in that order, Loop being the larger of AngleIterations and 16.
// Pipeline: 3 front stages, Loop cordic/root stages, one finish stage,
//   16 divider stages and an output register.
// Reset clears all valid bits and loads the default geometry.
// A stall on out_ready_i freezes the whole pipeline in place; nothing is
//   dropped or repeated, and input is taken again once it moves.
module swerve_drive_inverse_kinematics_top #(
  parameter int AngleIterations = swdik_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swdik_pkg::cmd_t      in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swdik_pkg::res_t      out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  logic [15:0] base_q, track_q, radius_q;
  logic        adv;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= swdik_pkg::BASE_RST;
      track_q  <= swdik_pkg::TRACK_RST;
      radius_q <= swdik_pkg::RADIUS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        swdik_pkg::CFG_BASE:   base_q   <= cfg_data_i;
        swdik_pkg::CFG_TRACK:  track_q  <= cfg_data_i;
        swdik_pkg::CFG_RADIUS: radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output register can take an item
  assign adv = !out_valid_o || out_ready_i;

  logic             f_v, c_v, d_v;
  swdik_pkg::loop_t f_d, c_d;
  swdik_pkg::div_t  d_d;

  swdik_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .base_i      (base_q),
    .track_i     (track_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (f_v),
    .out_data_o  (f_d)
  );

  swdik_cordic #(
    .AngleIterations (AngleIterations)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (f_v),
    .in_data_i   (f_d),
    .out_valid_o (c_v),
    .out_data_o  (c_d)
  );

  swdik_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .radius_i    (radius_q),
    .in_valid_i  (c_v),
    .in_data_i   (c_d),
    .out_valid_o (d_v),
    .out_data_o  (d_d)
  );

  // output register
  logic            out_v_q;
  swdik_pkg::res_t out_q, out_d;

  always_comb begin
    out_d.wheel_index  = d_d.k;
    out_d.pivot_angle  = d_d.angle;
    out_d.linear_speed = d_d.speed;
    out_d.last_wheel   = d_d.k == 2'd3;
    if (d_d.zero) begin
      out_d.wheel_rate = 16'd0;
    end else if (d_d.sat) begin
      out_d.wheel_rate = 16'hFFFF;
    end else begin
      out_d.wheel_rate = d_d.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // last flag marks exactly the rear-right wheel
  a_last_rr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_wheel == (out_data_o.wheel_index == 2'd3)))
    else $error("last_wheel does not match wheel index");

  // a standing wheel never spins
  a_zero_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.linear_speed == 16'd0)) |-> (out_data_o.wheel_rate == 16'd0))
    else $error("nonzero wheel rate at zero speed");

  // steering angle stays within plus or minus pi
  a_angle_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.pivot_angle <= 16'sd25736) &&
                     (out_data_o.pivot_angle >= -16'sd25736)))
    else $error("steering angle out of range");

  // a stalled output holds its item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output item changed while stalled");
`endif

endmodule
